/* hw/rtl/arithmetic_mask_modular_unit_macros.svh */
// Assertion macros shared by the masking unit RTL.
`ifndef ARITHMETIC_MASK_MODULAR_UNIT_MACROS_SVH
`define ARITHMETIC_MASK_MODULAR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AMM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define AMM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* hw/rtl/amm_pkg.sv */
// Types, constants and helper functions of the arithmetic masking unit.
package amm_pkg;

	localparam int DATA_W      = 32;
	localparam int HALF_W      = 16;
	localparam int WIDE_W      = 64;
	localparam int REM_W       = 31;
	localparam int CELLS       = 64;
	localparam int LANES       = 2;
	localparam int IN_TDATA_W  = 136;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W   = 1;

	typedef enum logic [1:0] {
		FUNC_MASK   = 2'd0,
		FUNC_UNMASK = 2'd1,
		FUNC_MUL    = 2'd2,
		FUNC_NONE   = 2'd3
	} amm_func_t;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_MODE = 1'b1;

	typedef struct packed {
		amm_func_t         func;
		logic              mode;
		logic [DATA_W-1:0] a;
	} amm_side_t;

	typedef struct packed {
		logic [WIDE_W-1:0] mag;
		logic              neg;
		logic [REM_W-1:0]  rem;
	} amm_lane_t;

	typedef struct packed {
		logic                  red;
		logic [DATA_W-1:0]     q;
		amm_side_t             side;
		amm_lane_t [LANES-1:0] lane;
	} amm_cell_t;

	function automatic logic [DATA_W-1:0] sext_half(input logic [HALF_W-1:0] v);
		return {{(DATA_W-HALF_W){v[HALF_W-1]}}, v};
	endfunction

	function automatic logic [DATA_W-1:0] fit_word(input logic mode,
		input logic [DATA_W-1:0] v);
		return mode ? v : sext_half(v[HALF_W-1:0]);
	endfunction

	function automatic logic [WIDE_W-1:0] sext_wide(input logic [DATA_W-1:0] v);
		return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

endpackage

/* hw/rtl/arithmetic_mask_modular_unit.sv */
// Top level of the first-order arithmetic masking unit modulo q.
// Throughput is one transaction per cycle while m_tready does not stall the output,
// carried by two 64-cell reduction chains in series.
// Each cell of a chain resolves one dividend bit for both lanes.
// Reset clears all valid flags, sets modulus to zero and word_mode to one.
`include "arithmetic_mask_modular_unit_macros.svh"
module arithmetic_mask_modular_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// func, operand_value, mask_in, multiplier, random_word, zero padding
	input  logic [amm_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// share, out_mask
	output logic [amm_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                 cfg_we,
	input  logic [amm_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [amm_pkg::DATA_W-1:0]           cfg_wdata
);
	import amm_pkg::*;

	logic                          adv;
	logic [DATA_W-1:0]             modulus_q;
	logic                          word_mode_q;
	logic [DATA_W-1:0]             q_fit;

	logic                          valid_s1;
	amm_func_t                     func_s1;
	logic                          mode_s1;
	logic                          red_s1;
	logic [DATA_W-1:0]             q_s1;
	logic [DATA_W-1:0]             op_s1;
	logic [DATA_W-1:0]             rin_s1;
	logic [DATA_W-1:0]             mul_s1;
	logic [DATA_W-1:0]             rnd_s1;

	logic [DATA_W-1:0]             x1;
	logic [DATA_W-1:0]             y1;
	logic [DATA_W-1:0]             rsrc1;
	amm_side_t                     side1;
	logic [LANES-1:0][WIDE_W-1:0]  val1;

	logic                          c1_valid;
	logic                          c1_red;
	logic [DATA_W-1:0]             c1_q;
	amm_side_t                     c1_side;
	logic [LANES-1:0][WIDE_W-1:0]  c1_val;

	logic [DATA_W:0]               qx;
	logic [DATA_W:0]               sum2;
	logic [DATA_W:0]               diff2;

	logic                          valid_s2;
	amm_func_t                     func_s2;
	logic                          mode_s2;
	logic                          red_s2;
	logic [DATA_W-1:0]             q_s2;
	logic [DATA_W-1:0]             a_s2;
	logic [DATA_W-1:0]             xm_s2;
	logic [DATA_W-1:0]             rr_s2;
	logic [DATA_W-1:0]             sum_s2;
	logic [DATA_W-1:0]             diff_s2;

	logic [WIDE_W-1:0]             p0;
	logic [WIDE_W-1:0]             p1;
	logic [LANES-1:0][WIDE_W-1:0]  lane3;

	logic                          valid_s3;
	logic                          mode_s3;
	amm_func_t                     func_s3;
	logic                          red_s3;
	logic [DATA_W-1:0]             q_s3;
	logic [LANES-1:0][WIDE_W-1:0]  val_s3;
	amm_side_t                     side3;

	logic                          c2_valid;
	logic                          c2_red;
	logic [DATA_W-1:0]             c2_q;
	amm_side_t                     c2_side;
	logic [LANES-1:0][WIDE_W-1:0]  c2_val;

	logic                          out_valid_q;
	logic [OUT_TDATA_W-1:0]        out_data_q;

	logic                          c2_in_range;
	logic                          q_pos32;
	logic                          out_reduced;
	logic                          out_half;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= '0;
			word_mode_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MODULUS:   modulus_q   <= cfg_wdata;
				REG_WORD_MODE: word_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign q_fit = fit_word(word_mode_q, modulus_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			func_s1 <= amm_func_t'(s_tdata[1:0]);
			op_s1   <= s_tdata[33:2];
			rin_s1  <= s_tdata[65:34];
			mul_s1  <= s_tdata[97:66];
			rnd_s1  <= s_tdata[129:98];
			mode_s1 <= word_mode_q;
			q_s1    <= q_fit;
			red_s1  <= $signed(q_fit) > 0;
		end
	end

	always_comb begin
		x1 = fit_word(mode_s1, op_s1);
		if (mode_s1) begin
			rsrc1 = rnd_s1;
		end else if (red_s1) begin
			rsrc1 = {{(DATA_W-HALF_W){1'b0}}, rnd_s1[HALF_W-1:0]};
		end else begin
			rsrc1 = sext_half(rnd_s1[HALF_W-1:0]);
		end
		y1 = (func_s1 == FUNC_UNMASK) ? fit_word(mode_s1, rin_s1) : rsrc1;
		side1.func = func_s1;
		side1.mode = mode_s1;
		side1.a    = fit_word(mode_s1, mul_s1);
		val1[0]    = sext_wide(x1);
		val1[1]    = sext_wide(y1);
	end

	amm_red_chain u_chain_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.up_valid (valid_s1),
		.up_red   (red_s1),
		.up_q     (q_s1),
		.up_side  (side1),
		.up_val   (val1),
		.dn_valid (c1_valid),
		.dn_red   (c1_red),
		.dn_q     (c1_q),
		.dn_side  (c1_side),
		.dn_val   (c1_val)
	);

	always_comb begin
		qx    = {1'b0, c1_q};
		sum2  = {c1_val[0][DATA_W-1], c1_val[0][DATA_W-1:0]}
			+ {c1_val[1][DATA_W-1], c1_val[1][DATA_W-1:0]};
		diff2 = {c1_val[0][DATA_W-1], c1_val[0][DATA_W-1:0]}
			- {c1_val[1][DATA_W-1], c1_val[1][DATA_W-1:0]};
		if (c1_red && ($signed(sum2) >= $signed(qx))) begin
			sum2 = sum2 - qx;
		end
		if (c1_red && diff2[DATA_W]) begin
			diff2 = diff2 + qx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= c1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s2 <= c1_side.func;
			mode_s2 <= c1_side.mode;
			red_s2  <= c1_red;
			q_s2    <= c1_q;
			a_s2    <= c1_side.a;
			xm_s2   <= fit_word(c1_side.mode, sum2[DATA_W-1:0]);
			rr_s2   <= c1_val[1][DATA_W-1:0];
			sum_s2  <= sum2[DATA_W-1:0];
			diff_s2 <= diff2[DATA_W-1:0];
		end
	end

	assign p0 = WIDE_W'($signed(a_s2) * $signed(xm_s2));
	assign p1 = WIDE_W'($signed(a_s2) * $signed(rr_s2));

	always_comb begin
		case (func_s2)
			FUNC_MASK: begin
				lane3[0] = sext_wide(sum_s2);
				lane3[1] = sext_wide(rr_s2);
			end
			FUNC_UNMASK: begin
				lane3[0] = sext_wide(diff_s2);
				lane3[1] = '0;
			end
			FUNC_MUL: begin
				lane3[0] = p0;
				lane3[1] = p1;
			end
			default: begin
				lane3[0] = '0;
				lane3[1] = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3 <= mode_s2;
			func_s3 <= func_s2;
			red_s3  <= red_s2;
			q_s3    <= q_s2;
			val_s3  <= lane3;
		end
	end

	assign side3.func = func_s3;
	assign side3.mode = mode_s3;
	assign side3.a    = '0;

	amm_red_chain u_chain_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.up_valid (valid_s3),
		.up_red   (red_s3),
		.up_q     (q_s3),
		.up_side  (side3),
		.up_val   (val_s3),
		.dn_valid (c2_valid),
		.dn_red   (c2_red),
		.dn_q     (c2_q),
		.dn_side  (c2_side),
		.dn_val   (c2_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= c2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {fit_word(c2_side.mode, c2_val[1][DATA_W-1:0]),
				fit_word(c2_side.mode, c2_val[0][DATA_W-1:0])};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign c2_in_range = (c2_val[0] < WIDE_W'(c2_q)) && (c2_val[1] < WIDE_W'(c2_q));
	assign q_pos32     = word_mode_q && ($signed(modulus_q) > 0);
	assign out_reduced = (m_tdata[31:0] < modulus_q) && (m_tdata[63:32] < modulus_q);
	assign out_half    = (m_tdata[31:16] == {16{m_tdata[15]}}) &&
		(m_tdata[63:48] == {16{m_tdata[47]}});

	`AMM_ASSERT_IMPLY(a_share_in_range, clk, arst_n, c2_valid && c2_red, c2_in_range)
	`AMM_ASSERT_IMPLY(a_reduced_range, clk, arst_n, m_tvalid && q_pos32, out_reduced)
	`AMM_ASSERT_IMPLY(a_half_extend, clk, arst_n, m_tvalid && !word_mode_q, out_half)
	`AMM_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1 && (q_s1 == $past(q_s1)))

endmodule

/* hw/rtl/amm_red_cell.sv */
// One cell of the reduction chain: takes one dividend bit into the remainder of each lane.
module amm_red_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                up_valid,
	input  amm_pkg::amm_cell_t  up_data,
	output logic                dn_valid,
	output amm_pkg::amm_cell_t  dn_data
);
	import amm_pkg::*;

	amm_cell_t        nxt;
	logic [REM_W:0]   t [LANES];
	logic [REM_W:0]   qz;
	logic             valid_q;
	amm_cell_t        cell_q;

	assign qz = {1'b0, up_data.q[REM_W-1:0]};

	always_comb begin
		nxt = up_data;
		for (int i = 0; i < LANES; i++) begin
			t[i] = {up_data.lane[i].rem, up_data.lane[i].mag[WIDE_W-1]};
			if (up_data.red && (t[i] >= qz)) begin
				t[i] = t[i] - qz;
			end
			nxt.lane[i].rem = t[i][REM_W-1:0];
			nxt.lane[i].mag = {up_data.lane[i].mag[WIDE_W-2:0],
				up_data.lane[i].mag[WIDE_W-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = cell_q;

endmodule

/* hw/rtl/amm_red_chain.sv */
// Cell chain: two signed 64-bit lanes modulo q, or as is if red is low.
module amm_red_chain (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          en,
	input  logic                                          up_valid,
	input  logic                                          up_red,
	input  logic [amm_pkg::DATA_W-1:0]                    up_q,
	input  amm_pkg::amm_side_t                            up_side,
	input  logic [amm_pkg::LANES-1:0][amm_pkg::WIDE_W-1:0] up_val,
	output logic                                          dn_valid,
	output logic                                          dn_red,
	output logic [amm_pkg::DATA_W-1:0]                    dn_q,
	output amm_pkg::amm_side_t                            dn_side,
	output logic [amm_pkg::LANES-1:0][amm_pkg::WIDE_W-1:0] dn_val
);
	import amm_pkg::*;

	amm_cell_t                   head;
	amm_cell_t                   stage [CELLS+1];
	logic                        vld   [CELLS+1];
	amm_cell_t                   last;
	logic [REM_W-1:0]            fix   [LANES];
	logic [LANES-1:0][WIDE_W-1:0] res;
	logic                        tail_valid_q;
	logic                        tail_red_q;
	logic [DATA_W-1:0]           tail_q_q;
	amm_side_t                   tail_side_q;
	logic [LANES-1:0][WIDE_W-1:0] tail_val_q;

	always_comb begin
		head.red  = up_red;
		head.q    = up_q;
		head.side = up_side;
		for (int i = 0; i < LANES; i++) begin
			head.lane[i].neg = up_val[i][WIDE_W-1];
			head.lane[i].mag = up_val[i][WIDE_W-1] ? (~up_val[i] + WIDE_W'(1)) : up_val[i];
			head.lane[i].rem = '0;
		end
	end
	assign stage[0] = head;
	assign vld[0] = up_valid;

	for (genvar c = 0; c < CELLS; c++) begin : g_cell
		amm_red_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (vld[c]),
			.up_data  (stage[c]),
			.dn_valid (vld[c+1]),
			.dn_data  (stage[c+1])
		);
	end

	assign last = stage[CELLS];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			fix[i] = (last.lane[i].neg && (last.lane[i].rem != '0)) ?
				(last.q[REM_W-1:0] - last.lane[i].rem) : last.lane[i].rem;
			if (last.red) begin
				res[i] = {{(WIDE_W-REM_W){1'b0}}, fix[i]};
			end else begin
				res[i] = last.lane[i].neg ? (~last.lane[i].mag + WIDE_W'(1)) :
					last.lane[i].mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_valid_q <= 1'b0;
		end else if (en) begin
			tail_valid_q <= vld[CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tail_red_q  <= last.red;
			tail_q_q    <= last.q;
			tail_side_q <= last.side;
			tail_val_q  <= res;
		end
	end

	assign dn_valid = tail_valid_q;
	assign dn_red   = tail_red_q;
	assign dn_q     = tail_q_q;
	assign dn_side  = tail_side_q;
	assign dn_val   = tail_val_q;

endmodule
